### hdl/sha_pkg.sv
// Package: SHA-256 hasher types, constants and round functions.
package sha_pkg;

    localparam int unsigned WordWidth = 32;

    typedef logic [31:0] t_word;

    // Command from controller to datapath.
    typedef struct packed {
        logic       load_byte;   // write byte into buffer at fill level
        logic       pad_byte;    // write pad byte at fill level
        logic       len_load;    // write length into the last 8 bytes
        logic       comp_start;  // load working vars, zero round count
        logic       comp_round;  // one round
        logic       comp_final;  // add working vars into chain
        logic       fill_clr;    // clear fill level
        logic       msg_init;    // restart message
        logic       len_latch;   // latch total bit length
        logic       blk_done;    // add 512 to bit total
    } t_dp_cmd;

    typedef struct packed {
        logic [6:0] fill;
        logic [5:0] round;
    } t_dp_stat;

    localparam logic [7:0] PadByte = 8'h80;
    localparam logic [6:0] LenPos  = 7'd56;
    localparam logic [6:0] BlkLen  = 7'd64;

    localparam t_word RoundK [64] = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,
        32'h3956c25b,32'h59f111f1,32'h923f82a4,32'hab1c5ed5,
        32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,
        32'he49b69c1,32'hefbe4786,32'h0fc19dc6,32'h240ca1cc,
        32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,
        32'hc6e00bf3,32'hd5a79147,32'h06ca6351,32'h14292967,
        32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,
        32'ha2bfe8a1,32'ha81a664b,32'hc24b8b70,32'hc76c51a3,
        32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,
        32'h391c0cb3,32'h4ed8aa4a,32'h5b9cca4f,32'h682e6ff3,
        32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
    };

    localparam t_word InitH [8] = '{
        32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
        32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19
    };

    function automatic t_word rotr(input t_word x, input int unsigned n);
        rotr = (x >> n) | (x << (WordWidth - n));
    endfunction

    function automatic t_word ssig0(input t_word x);
        ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word ssig1(input t_word x);
        ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic t_word bsig0(input t_word x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word bsig1(input t_word x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

### hdl/sha_if.sv
// Interfaces: byte input channel and digest output channel.
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
    modport source (output valid, data_byte, has_byte, end_of_message, input ready);
    modport sink   (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

### hdl/sha_datapath.sv
// Datapath: block buffer, message schedule, round unit, chain and bit count.
module sha_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sha_pkg::t_dp_cmd i_cmd,
    input  logic [7:0]       i_byte,
    input  logic [2:0]       i_word_sel,
    output sha_pkg::t_dp_stat o_stat,
    output sha_pkg::t_word   o_chain_word
);
    import sha_pkg::*;

    t_word       r_buf [16];
    logic [6:0]  r_fill, n_fill;
    logic [63:0] r_bits;
    logic [63:0] r_len;
    t_word       r_h [8];
    t_word       r_v [8];
    t_word       r_w [16];
    logic [5:0]  r_round;

    t_word t1, t2, w_cur, w_new;
    logic [4:0] lane_lsb;

    // Byte 0 of a word sits in the top lane.
    assign lane_lsb = {~r_fill[1:0], 3'd0};

    // Words 0..15 come from the buffer, later ones from the schedule window.
    always_comb begin
        w_new = ssig1(r_w[14]) + r_w[9] + ssig0(r_w[1]) + r_w[0];
        if (r_round < 6'd16)
            w_cur = r_buf[r_round[3:0]];
        else
            w_cur = w_new;
        t1 = r_v[7] + bsig1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
             + RoundK[r_round] + w_cur;
        t2 = bsig0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_comb begin
        n_fill = r_fill;
        if (i_cmd.load_byte || i_cmd.pad_byte)
            n_fill = r_fill + 7'd1;
        if (i_cmd.fill_clr || i_cmd.msg_init)
            n_fill = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_bits  <= '0;
            r_round <= '0;
            r_h     <= InitH;
        end else begin
            r_fill <= n_fill;
            if (i_cmd.blk_done)
                r_bits <= r_bits + 64'd512;
            if (i_cmd.comp_start)
                r_round <= '0;
            else if (i_cmd.comp_round)
                r_round <= r_round + 6'd1;
            if (i_cmd.comp_final) begin
                for (int i = 0; i < 8; i++)
                    r_h[i] <= r_h[i] + r_v[i];
            end
            if (i_cmd.msg_init) begin
                r_h    <= InitH;
                r_bits <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_byte)
            r_buf[r_fill[5:2]][lane_lsb +: 8] <= i_byte;
        else if (i_cmd.pad_byte)
            r_buf[r_fill[5:2]][lane_lsb +: 8] <= (r_fill[5:0] == r_len[8:3]) ?
                                                 PadByte : 8'h00;
        if (i_cmd.len_load) begin
            r_buf[14] <= r_len[63:32];
            r_buf[15] <= r_len[31:0];
        end
        if (i_cmd.len_latch)
            r_len <= r_bits + {54'd0, n_fill, 3'd0};
        if (i_cmd.comp_start)
            r_v <= r_h;
        else if (i_cmd.comp_round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
            for (int i = 0; i < 15; i++)
                r_w[i] <= r_w[i + 1];
            r_w[15] <= w_cur;
        end
    end

    assign o_stat.fill    = r_fill;
    assign o_stat.round   = r_round;
    assign o_chain_word   = r_h[i_word_sel];
endmodule

### hdl/sha_ctrl.sv
// Controller: sequences byte loads, padding, compression and digest output.
module sha_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_has_byte,
    input  logic              i_eom,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [2:0]        o_word_idx,
    input  sha_pkg::t_dp_stat i_stat,
    output sha_pkg::t_dp_cmd  o_cmd
);
    import sha_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_RUN   = 7'b0000010,
        S_FINAL = 7'b0000100,
        S_PAD   = 7'b0001000,
        S_LEN   = 7'b0010000,
        S_OUT   = 7'b0100000,
        S_START = 7'b1000000
    } t_state;

    t_state     r_state, n_state;
    logic       r_pad, n_pad;     // padding in progress
    logic       r_eom, n_eom;     // close message after current block
    logic [2:0] r_idx, n_idx;

    logic in_acc;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = (r_state == S_OUT);
    assign o_word_idx  = r_idx;

    always_comb begin
        n_state = r_state;
        n_pad   = r_pad;
        n_eom   = r_eom;
        n_idx   = r_idx;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    o_cmd.load_byte = i_has_byte;
                    n_eom = i_eom;
                    if (i_has_byte && i_stat.fill == BlkLen - 7'd1)
                        n_state = S_START;
                    else if (i_eom) begin
                        o_cmd.len_latch = 1'b1;
                        n_eom   = 1'b0;
                        n_state = S_PAD;
                    end
                end
            end
            S_START: begin
                o_cmd.comp_start = 1'b1;
                n_state = S_RUN;
            end
            S_RUN: begin
                o_cmd.comp_round = 1'b1;
                if (i_stat.round == 6'd63)
                    n_state = S_FINAL;
            end
            S_FINAL: begin
                o_cmd.comp_final = 1'b1;
                o_cmd.fill_clr   = 1'b1;
                if (!r_pad) begin
                    o_cmd.blk_done = 1'b1;
                    if (r_eom) begin
                        // length taken after the 512 add; latch in pad state
                        n_state = S_PAD;
                        n_pad   = 1'b1;
                    end else
                        n_state = S_IDLE;
                end else if (i_stat.fill == BlkLen) begin
                    n_state = S_PAD;
                end else begin
                    n_idx   = '0;
                    n_state = S_OUT;
                end
            end
            S_PAD: begin
                // a full block closed the message: latch the length first
                if (r_eom) begin
                    o_cmd.len_latch = 1'b1;
                    n_eom = 1'b0;
                end else begin
                    n_pad = 1'b1;
                    o_cmd.pad_byte = 1'b1;
                    if (i_stat.fill == BlkLen - 7'd1)
                        n_state = S_START;
                    else if (i_stat.fill == LenPos - 7'd1)
                        n_state = S_LEN;
                end
            end
            S_LEN: begin
                o_cmd.len_load = 1'b1;
                o_cmd.fill_clr = 1'b0;
                n_state = S_START;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        o_cmd.msg_init = 1'b1;
                        n_pad   = 1'b0;
                        n_eom   = 1'b0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pad   <= 1'b0;
            r_eom   <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_pad   <= n_pad;
            r_eom   <= n_eom;
            r_idx   <= n_idx;
        end
    end
endmodule

### hdl/sha256_stream_hasher.sv
// Top level: SHA-256 stream hasher, at most one message byte per input beat.
// A data beat is taken in idle; the 64th byte of a block starts a compression:
// start, rounds, final add. A closing beat writes the padding bytes and then the length,
// compresses one or two final blocks, then eight digest beats, one per cycle when taken.
// Throughput is set by the one-round-per-cycle unit; no byte is taken during compression.
// Synchronous active-low reset loads the initial hash values and clears counts.
module sha256_stream_hasher (
    input  logic  i_clk,
    input  logic  i_rst_n,
    sha_in_if.sink    i_in,
    sha_out_if.source o_out
);
    import sha_pkg::*;

    t_dp_cmd    cmd;
    t_dp_stat   stat;
    logic [2:0] word_idx;
    t_word      chain_word;

    // When no full block came, the length is latched before the first pad byte.
    sha_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_has_byte  (i_in.has_byte),
        .i_eom       (i_in.end_of_message),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_word_idx  (word_idx),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    sha_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_byte       (i_in.data_byte),
        .i_word_sel   (word_idx),
        .o_stat       (stat),
        .o_chain_word (chain_word)
    );

    assign o_out.digest_word = chain_word;
    assign o_out.word_index  = word_idx;
    assign o_out.last_word   = (word_idx == 3'd7);

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid)) else $error("input taken during digest");
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.fill <= BlkLen) else $error("fill level out of range");
    a_round_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.comp_round && stat.round != 6'd63 |=> stat.round == $past(stat.round) + 6'd1)
        else $error("round counter skipped");
endmodule

### tb/tb_sha256_stream_hasher.sv
// Testbench for the SHA-256 stream hasher: directed and random messages vs a digest predictor.
`timescale 1ns / 1ps

module tb_sha256_stream_hasher;
    import sha_pkg::*;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } t_byte_beat;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_digest_beat;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   error_count = 0;
    bit   hold_sender = 1'b0;

    sha_in_if  in_ch ();
    sha_out_if out_ch ();

    sha256_stream_hasher DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_byte_beat   pending_beats[$];
    t_digest_beat expected_words[$];

    // Predictor state
    t_word      chain_h[8];
    logic [63:0] bits_done;
    logic [7:0] msg_block[64];
    int         fill;

    function automatic t_word rot(t_word x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_msg_block();
        t_word w[64];
        t_word a, b, c, d, e, f, g, h, t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = (rot(w[i-2], 17) ^ rot(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
                 + (rot(w[i-15], 7) ^ rot(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
        a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
        e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
        for (int i = 0; i < 64; i++) begin
            t1 = h + (rot(e, 6) ^ rot(e, 11) ^ rot(e, 25)) + ((e & f) ^ (~e & g))
               + RoundK[i] + w[i];
            t2 = (rot(a, 2) ^ rot(a, 13) ^ rot(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
        chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
    endtask

    task automatic restart_digest();
        for (int i = 0; i < 8; i++) chain_h[i] = InitH[i];
        bits_done = '0;
        fill = 0;
    endtask

    task automatic absorb_beat(t_byte_beat bt);
        logic [63:0] total;
        t_digest_beat dw;
        if (bt.has_byte) begin
            msg_block[fill] = bt.data_byte;
            fill++;
            if (fill == 64) begin
                compress_msg_block();
                bits_done += 64'd512;
                fill = 0;
            end
        end
        if (!bt.end_of_message) return;
        total = bits_done + 64'(fill * 8);
        msg_block[fill] = PadByte;
        fill++;
        if (fill > 56) begin
            while (fill < 64) msg_block[fill++] = 8'h00;
            compress_msg_block();
            fill = 0;
        end
        while (fill < 56) msg_block[fill++] = 8'h00;
        for (int i = 0; i < 8; i++) msg_block[56+i] = total[63-8*i -: 8];
        compress_msg_block();
        for (int i = 0; i < 8; i++) begin
            dw.digest_word = chain_h[i];
            dw.word_index  = 3'(i);
            dw.last_word   = (i == 7);
            expected_words.push_back(dw);
        end
        restart_digest();
    endtask

    // Driver: bursts with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (in_ch.valid) absorb_beat({in_ch.data_byte, in_ch.has_byte, in_ch.end_of_message});
            if (gap_left > 0) begin
                gap_left--;
                in_ch.valid <= 1'b0;
            end else if (pending_beats.size() > 0 && !hold_sender) begin
                t_byte_beat bt;
                bt = pending_beats.pop_front();
                in_ch.valid          <= 1'b1;
                in_ch.data_byte      <= bt.data_byte;
                in_ch.has_byte       <= bt.has_byte;
                in_ch.end_of_message <= bt.end_of_message;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 20);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                end
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor with its own stall pattern
    int stall_phase = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected digest beat %h idx %0d last %0b", $time,
                             out_ch.digest_word, out_ch.word_index, out_ch.last_word);
                    error_count++;
                end else begin
                    t_digest_beat ex;
                    ex = expected_words.pop_front();
                    if (ex.digest_word !== out_ch.digest_word) begin
                        $display("%0t: digest_word expected %h actual %h", $time,
                                 ex.digest_word, out_ch.digest_word);
                        error_count++;
                    end
                    if (ex.word_index !== out_ch.word_index) begin
                        $display("%0t: word_index expected %0d actual %0d", $time,
                                 ex.word_index, out_ch.word_index);
                        error_count++;
                    end
                    if (ex.last_word !== out_ch.last_word) begin
                        $display("%0t: last_word expected %0b actual %0b", $time,
                                 ex.last_word, out_ch.last_word);
                        error_count++;
                    end
                end
            end
            stall_phase = (stall_phase + 1) % 97;
            if (stall_phase < 30) out_ch.ready <= 1'b1;
            else if (stall_phase < 40) out_ch.ready <= stall_phase[0];
            else out_ch.ready <= ($urandom_range(0, 2) != 0);
        end
    end

    task automatic queue_message(int len, int mode);
        t_byte_beat bt;
        for (int i = 0; i < len; i++) begin
            bt.data_byte = (mode == 1) ? 8'hff : (mode == 2) ? 8'h00 : 8'($urandom);
            bt.has_byte = 1'b1;
            bt.end_of_message = (i == len - 1) && ($urandom_range(0, 1) == 1);
            if ($urandom_range(0, 15) == 0) begin
                // interleave a beat that does nothing
                pending_beats.push_back({8'($urandom), 1'b0, 1'b0});
            end
            pending_beats.push_back(bt);
            if (bt.end_of_message) return;
        end
        pending_beats.push_back({8'($urandom), 1'b0, 1'b1});
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data_byte = '0;
        in_ch.has_byte = 1'b0;
        in_ch.end_of_message = 1'b0;
        out_ch.ready = 1'b0;
        restart_digest();
        for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;

        // directed: idle beat, empty message, one byte with end, three-byte message with a separate end beat
        pending_beats.push_back({8'hff, 1'b0, 1'b0});
        pending_beats.push_back({8'h00, 1'b0, 1'b1});
        pending_beats.push_back({8'hff, 1'b1, 1'b1});
        pending_beats.push_back({8'h00, 1'b1, 1'b0});
        pending_beats.push_back({8'h55, 1'b1, 1'b0});
        pending_beats.push_back({8'haa, 1'b1, 1'b0});
        pending_beats.push_back({8'h00, 1'b0, 1'b1});

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_beats.size() == 0 && !in_ch.valid);
        wait (expected_words.size() == 0);
        repeat (20) @(posedge i_clk);

        // padding edges: 55/56/64 bytes; 56 needs a second final block
        queue_message(55, 1);
        queue_message(56, 2);
        queue_message(64, 0);

        // pause the sender until every digest has drained
        wait (pending_beats.size() == 0 && !in_ch.valid);
        hold_sender = 1'b1;
        wait (expected_words.size() == 0);
        repeat (200) @(posedge i_clk);
        hold_sender = 1'b0;

        while (pending_beats.size() < 30)
            queue_message($urandom_range(1, 12), 0);

        wait (pending_beats.size() == 0 && !in_ch.valid);
        wait (expected_words.size() == 0);
        repeat (300) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
